// ===== hw/rtl/msap_pkg.sv =====
// Package for the max-sum-after-partitioning block: widths, payload words,
// sequencer states, per-cell control struct and a four-way maximum helper.
// No dependencies.
package msap_pkg;

  localparam int MAX_K   = 16;   // cells in the chain, longest piece
  localparam int VAL_W   = 16;   // element width
  localparam int LEN_W   = 5;    // piece length / limit width
  localparam int CNT_W   = 5;    // seen count, holds 0..MAX_K
  localparam int SUM_W   = 32;   // running total width
  localparam int PROD_W  = VAL_W + LEN_W;
  localparam int GRP_N   = MAX_K / 4;

  localparam logic [SUM_W-1:0] SUM_CAP = {SUM_W{1'b1}};

  typedef struct packed {
    logic [VAL_W-1:0] elem_value;
    logic             elem_last;
  } elem_t;

  typedef struct packed {
    logic [SUM_W-1:0] best_sum;
    logic             sum_last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CAND,
    ST_REDUCE,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic shift;   // take new element into the suffix maxima
    logic calc;    // form the candidate total
    logic commit;  // shift the new best total into the chain
    logic clear;   // wipe array state with the commit
  } cell_ctrl_t;

  function automatic logic [SUM_W-1:0] max4(input logic [SUM_W-1:0] a,
                                            input logic [SUM_W-1:0] b,
                                            input logic [SUM_W-1:0] c,
                                            input logic [SUM_W-1:0] d);
    logic [SUM_W-1:0] ab;
    logic [SUM_W-1:0] cd;
    ab = (a > b) ? a : b;
    cd = (c > d) ? c : d;
    return (ab > cd) ? ab : cd;
  endfunction

endpackage

// ===== hw/rtl/max_sum_after_partitioning_unit.sv =====
// Top level of the max-sum-after-partitioning block: sequencer, cell chain,
// two-level max tree and output register. Depends on msap_pkg, msap_cell.
// Order: an element is taken in idle, its candidates registered in the candidate
// state, the 16-to-4 max stage registered in reduce and the 4-to-1 commit stage
// feeds the result register in commit. No new element is taken until the last one
// commits; a stalled output word holds the sequencer in commit until it is taken.
// Reset: all array state, the seen count and the output valid clear; limit is 1.
module max_sum_after_partitioning_unit import msap_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  elem_t            in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output result_t          out_data_o
);

  state_e           state_q, state_d;
  logic [LEN_W-1:0] cfg_len_q;
  logic [LEN_W-1:0] limit_q, limit_d;
  logic [CNT_W-1:0] seen_q, seen_d;
  logic             last_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_data_q;
  logic             accept;
  logic             out_free;
  logic             reduce;
  cell_ctrl_t       ctrl;
  logic [SUM_W-1:0] grp_q [GRP_N];
  logic [SUM_W-1:0] best;
  logic [LEN_W-1:0] len_clamp;
  logic [CNT_W:0]   avail;

  logic [VAL_W-1:0] sm    [MAX_K];
  logic [SUM_W-1:0] prior [MAX_K];
  logic [SUM_W-1:0] cand  [MAX_K];

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CAND;
        end
      end
      ST_CAND:   state_d = ST_REDUCE;
      ST_REDUCE: state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o  = 1'b1;
    reduce      = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.calc   = 1'b0;
    ctrl.commit = 1'b0;
    ctrl.clear  = last_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ctrl.shift = in_valid_i;
      end
      ST_CAND:   ctrl.calc = 1'b1;
      ST_REDUCE: reduce = 1'b1;
      ST_COMMIT: ctrl.commit = out_free;
      default:   in_stall_o = 1'b1;
    endcase
  end

  // Effective piece limit: zero acts as one, cap at chain length and count
  always_comb begin
    if (cfg_len_q == '0) begin
      len_clamp = LEN_W'(1);
    end else if (cfg_len_q > LEN_W'(MAX_K)) begin
      len_clamp = LEN_W'(MAX_K);
    end else begin
      len_clamp = cfg_len_q;
    end
    avail = {1'b0, seen_q} + (CNT_W + 1)'(1);
    if (avail > (CNT_W + 1)'(MAX_K)) begin
      avail = (CNT_W + 1)'(MAX_K);
    end
    limit_d = limit_q;
    if (accept) begin
      limit_d = ((CNT_W + 1)'(len_clamp) > avail) ? LEN_W'(avail) : len_clamp;
    end
  end

  // Seen count: advance on commit, saturate, drop after the last word
  always_comb begin
    seen_d = seen_q;
    if (ctrl.commit) begin
      if (last_q) begin
        seen_d = '0;
      end else if (seen_q < CNT_W'(MAX_K)) begin
        seen_d = seen_q + CNT_W'(1);
      end
    end
  end

  assign best = max4(grp_q[0], grp_q[1], grp_q[2], grp_q[3]);

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_len_q   <= LEN_W'(1);
      limit_q     <= LEN_W'(1);
      seen_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        last_q <= in_data_i.elem_last;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_len_q <= cfg_data_i;
      end
    end
  end

  // Registered first level of the max tree and the result word
  always_ff @(posedge clk_i) begin
    if (reduce) begin
      for (int g = 0; g < GRP_N; g++) begin
        grp_q[g] <= max4(cand[4*g], cand[4*g+1], cand[4*g+2], cand[4*g+3]);
      end
    end
    if (ctrl.commit) begin
      out_data_q.best_sum <= best;
      out_data_q.sum_last <= last_q;
    end
  end

  // Chain of cells, cell j holds the piece of length j+1
  for (genvar j = 0; j < MAX_K; j++) begin : g_cell
    logic [VAL_W-1:0] sm_prev;
    logic [SUM_W-1:0] best_prev;
    if (j == 0) begin : g_head
      assign sm_prev   = '0;
      assign best_prev = best;
    end else begin : g_body
      assign sm_prev   = sm[j-1];
      assign best_prev = prior[j-1];
    end
    msap_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .value_i     (in_data_i.elem_value),
      .sm_prev_i   (sm_prev),
      .best_prev_i (best_prev),
      .weight_i    (LEN_W'(j + 1)),
      .enable_i    (LEN_W'(j) < limit_q),
      .sm_o        (sm[j]),
      .best_o      (prior[j]),
      .cand_o      (cand[j])
    );
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/msap_cell.sv =====
// One cell of the partition chain: suffix maximum, prior best total and the
// candidate for a last piece of this cell's length. Depends on msap_pkg.
module msap_cell import msap_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic [VAL_W-1:0] sm_prev_i,
  input  logic [SUM_W-1:0] best_prev_i,
  input  logic [LEN_W-1:0] weight_i,
  input  logic             enable_i,
  output logic [VAL_W-1:0] sm_o,
  output logic [SUM_W-1:0] best_o,
  output logic [SUM_W-1:0] cand_o
);

  logic [VAL_W-1:0]  sm_q, sm_d;
  logic [SUM_W-1:0]  prior_q, prior_d;
  logic [SUM_W-1:0]  cand_q, cand_d;
  logic [PROD_W-1:0] piece;
  logic [SUM_W:0]    total;

  // Advance suffix maximum and prior total along the chain
  always_comb begin
    sm_d    = sm_q;
    prior_d = prior_q;
    if (ctrl_i.shift) begin
      sm_d = (sm_prev_i > value_i) ? sm_prev_i : value_i;
    end
    if (ctrl_i.commit) begin
      prior_d = ctrl_i.clear ? '0 : best_prev_i;
      if (ctrl_i.clear) begin
        sm_d = '0;
      end
    end
  end

  // Candidate: prior total plus piece maximum times piece length, saturating; zero when disabled
  always_comb begin
    piece = PROD_W'(sm_q) * PROD_W'(weight_i);
    total = {1'b0, prior_q} + (SUM_W + 1)'(piece);
    if (!enable_i) begin
      cand_d = '0;
    end else if (total[SUM_W]) begin
      cand_d = SUM_CAP;
    end else begin
      cand_d = total[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_q    <= '0;
      prior_q <= '0;
    end else begin
      sm_q    <= sm_d;
      prior_q <= prior_d;
    end
  end

  // Hold candidate for the max tree
  always_ff @(posedge clk_i) begin
    if (ctrl_i.calc) begin
      cand_q <= cand_d;
    end
  end

  assign sm_o   = sm_q;
  assign best_o = prior_q;
  assign cand_o = cand_q;

endmodule

// ===== dv/tb.sv =====
// Testbench for max_sum_after_partitioning_unit: directed and random arrays with
// a built-in partition-sum predictor and in-order result checking.
// Depends on msap_pkg and the RTL top level.
module tb;
  import msap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 4000000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          LONG_ELEMS   = 200;
  localparam logic [15:0] VAL_MAX      = 16'hFFFF;

  // DUT connections; the inputs are driven from time zero
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [LEN_W-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  elem_t            in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  result_t          out_data_o;

  // Stimulus and scoreboard stores
  elem_t   pending_elems[$];
  result_t expected_sums[$];
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  bit      elem_took      = 1'b0;

  // Predictor state
  logic [LEN_W-1:0] part_len_cfg = LEN_W'(1);
  logic [VAL_W-1:0] suffix_max [MAX_K] = '{default: '0};
  logic [SUM_W-1:0] prefix_best[MAX_K] = '{default: '0};
  int               seen_elems = 0;

  // Sender and receiver pacing
  int burst_left  = 1;
  int gap_left    = 0;
  int stall_cycle = 0;
  int stall_mode  = 0;
  int hold_count  = 0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;

  max_sum_after_partitioning_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Advance the partition DP by one element and return the expected word
  function automatic result_t predict_best_sum(elem_t e);
    int               lim;
    int               avail;
    logic [SUM_W:0]   cand;
    logic [SUM_W-1:0] best;
    result_t          r;
    lim = part_len_cfg;
    if (lim == 0) lim = 1;
    if (lim > MAX_K) lim = MAX_K;
    avail = seen_elems + 1;
    if (avail > MAX_K) avail = MAX_K;
    if (lim > avail) lim = avail;
    for (int j = MAX_K - 1; j > 0; j--) begin
      suffix_max[j] = (suffix_max[j-1] > e.elem_value) ? suffix_max[j-1] : e.elem_value;
    end
    suffix_max[0] = e.elem_value;
    best = '0;
    for (int j = 1; j <= lim; j++) begin
      cand = {1'b0, prefix_best[j-1]}
           + (SUM_W+1)'(suffix_max[j-1]) * (SUM_W+1)'(j);
      if (cand > {1'b0, SUM_CAP}) cand = {1'b0, SUM_CAP};
      if (cand[SUM_W-1:0] > best) best = cand[SUM_W-1:0];
    end
    for (int j = MAX_K - 1; j > 0; j--) begin
      prefix_best[j] = prefix_best[j-1];
    end
    prefix_best[0] = best;
    if (seen_elems < MAX_K) seen_elems++;
    // Drop all array state after the closing element; the limit stays
    if (e.elem_last) begin
      suffix_max  = '{default: '0};
      prefix_best = '{default: '0};
      seen_elems  = 0;
    end
    r.best_sum = best;
    r.sum_last = e.elem_last;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Monitor: sample handshakes at the rising edge, check results, predict
  always @(posedge clk_i) begin
    result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      elem_took = rst_ni && in_valid_i && !in_stall_o;
      if (rst_ni && cfg_valid_i && cfg_ready_o) part_len_cfg = cfg_data_i;
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_sums.size() == 0) begin
          report_mismatch("unexpected result word", out_data_o.best_sum, 0);
        end else begin
          want = expected_sums.pop_front();
          if (out_data_o.best_sum !== want.best_sum)
            report_mismatch("best_sum", out_data_o.best_sum, want.best_sum);
          if (out_data_o.sum_last !== want.sum_last)
            report_mismatch("sum_last", out_data_o.sum_last, want.sum_last);
        end
      end
      if (elem_took) expected_sums.push_back(predict_best_sum(in_data_i));
    end
  end

  // Driver: hold a stalled word, otherwise send in bursts with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !elem_took) begin
      in_valid_i <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid_i <= 1'b0;
    end else if (pending_elems.size() != 0) begin
      in_data_i  <= pending_elems.pop_front();
      in_valid_i <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: one long hold-off on request, otherwise a changing stall pattern
  always @(negedge clk_i) begin
    stall_cycle++;
    if (hold_req && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
    end else begin
      if (stall_cycle % 80 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_stall_i <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  task automatic push_elem(input logic [VAL_W-1:0] value, input logic last);
    elem_t e;
    e.elem_value = value;
    e.elem_last  = last;
    pending_elems.push_back(e);
  endtask

  // Wait until every word is sent and answered, then let the pipeline settle
  task automatic wait_drained();
    while (pending_elems.size() != 0 || expected_sums.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_part_len(input logic [LEN_W-1:0] len);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Queue random arrays; the final one may be cut off without its last flag
  task automatic queue_random_arrays(input int count);
    int               left;
    int               len;
    int               pick;
    int               mode;
    logic [VAL_W-1:0] v;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) len = $urandom_range(1, 20);
      else if (pick < 95) len = $urandom_range(21, 60);
      else len = $urandom_range(61, 120);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < len && left > 0; i++) begin
        case (mode)
          0: v = VAL_W'($urandom_range(0, 65535));
          1: v = VAL_W'($urandom_range(0, 15));
          2: v = $urandom_range(0, 1) ? VAL_MAX : '0;
          default: v = VAL_W'($urandom_range(65000, 65535));
        endcase
        push_elem(v, i == len - 1);
        left--;
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    int plan[8];
    plan = '{2, 16, 0, 31, 1, 4, 8, 17};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset limit of one: single-element arrays at both extremes and a two-element array
    push_elem(16'd0, 1'b1);
    push_elem(VAL_MAX, 1'b1);
    push_elem(16'd3, 1'b0);
    push_elem(16'd9, 1'b1);

    // Classic case with pieces of up to three
    write_part_len(5'd3);
    push_elem(16'd1, 1'b0);
    push_elem(16'd15, 1'b0);
    push_elem(16'd7, 1'b0);
    push_elem(16'd9, 1'b0);
    push_elem(16'd2, 1'b0);
    push_elem(16'd5, 1'b0);
    push_elem(16'd10, 1'b1);

    // Zero limit behaves as one
    write_part_len(5'd0);
    push_elem(VAL_MAX, 1'b0);
    push_elem(16'd0, 1'b0);
    push_elem(VAL_MAX, 1'b1);

    // Limit above the chain depth clamps to it
    write_part_len(5'd31);
    for (int i = 0; i < 10; i++) push_elem(16'(1000 - 90 * i), i == 9);

    // Long array of maximum values builds a large running total
    write_part_len(5'd16);
    for (int i = 0; i < LONG_ELEMS; i++) push_elem(VAL_MAX, i == LONG_ELEMS - 1);

    // Random phases over several limits; one phase carries the long hold-off
    for (int p = 0; p < 10; p++) begin
      if (p < 8) write_part_len(5'(plan[p]));
      else write_part_len(5'($urandom_range(0, 31)));
      if (p == 1) hold_req = 1'b1;
      queue_random_arrays(150);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
